/* rtl/wbs_pkg.sv */
package wbs_pkg;

  localparam int MAX_WORDS    = 64;
  localparam int MAX_WORD_LEN = 16;

  // word index, word count (holds MAX_WORDS), length (holds MAX_WORD_LEN), byte position
  localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WCNT_W = $clog2(MAX_WORDS + 1);
  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
  localparam int POS_W  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

  localparam int SYM_W  = 8;
  localparam int KIND_W = 2;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_DICT  = 2'd0;
  localparam kind_t KIND_TEXT  = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic              dict_wr;
    logic              clear;
    logic              text_start;
    logic              rd_en;
    logic [WIDX_W-1:0] rd_addr;
    logic              finish;
  } wbs_cmd_t;

  typedef struct packed {
    logic [WCNT_W-1:0] word_count;
  } wbs_sts_t;

endpackage

/* rtl/wbs_ctrl.sv */
module wbs_ctrl
  import wbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  kind_t    in_kind,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  wbs_sts_t sts,
  output wbs_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [WIDX_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              scan_last;
  logic              slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;
  assign scan_last  = ({1'b0, cnt_r} == (sts.word_count - WCNT_W'(1)));

  always_comb begin
    cmd.dict_wr    = accept && (in_kind == KIND_DICT);
    cmd.clear      = accept && (in_kind == KIND_CLEAR);
    cmd.text_start = accept && (in_kind == KIND_TEXT);
    cmd.rd_en      = (state_r == S_SCAN);
    cmd.rd_addr    = cnt_r;
    cmd.finish     = (state_r == S_FINISH) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.text_start) begin
          cnt_nxt = '0;
          // an empty table has nothing to scan
          state_nxt = (sts.word_count == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + WIDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/wbs_datapath.sv */
module wbs_datapath
  import wbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SYM_W-1:0] in_sym,
  input  logic             in_last,
  input  wbs_cmd_t         cmd,
  output wbs_sts_t         sts,
  output logic             prefix_ok,
  output logic             text_last,
  output logic             dict_overflow
);

  // word table: one row per word, one byte lane per character
  logic [MAX_WORD_LEN-1:0][SYM_W-1:0] chars_mem [MAX_WORDS];
  logic [LEN_W-1:0]                   len_mem   [MAX_WORDS];

  logic [MAX_WORD_LEN-1:0][SYM_W-1:0] row_q;
  logic [LEN_W-1:0]                   len_q;

  logic [WCNT_W-1:0] wc_r, wc_nxt;
  logic [LEN_W-1:0]  ll_r, ll_nxt;
  logic              too_long_r, too_long_nxt;
  logic              ovf_r, ovf_nxt;
  logic [MAX_WORD_LEN-1:0][SYM_W-1:0] win_r, win_nxt;
  logic [MAX_WORD_LEN:0] bh_r, bh_nxt;
  logic [LEN_W-1:0]  cs_r, cs_nxt;
  logic              rd_vld_r;
  logic              ok_r, ok_nxt;
  logic              last_r;
  logic              prefix_q, text_last_q, ovf_q;

  logic              ll_full, tbl_full, too_long_eff, commit;
  logic [LEN_W-1:0]  ll_inc;
  logic [WIDX_W-1:0] wc_idx;
  logic [POS_W-1:0]  ll_idx;

  logic [MAX_WORD_LEN-1:0] eq_vec;
  logic [LEN_W-1:0]  pos;
  logic [LEN_W-1:0]  len_m1;
  logic              bh_sel;
  logic              hit;

  assign sts.word_count = wc_r;
  assign prefix_ok      = prefix_q;
  assign text_last      = text_last_q;
  assign dict_overflow  = ovf_q;

  assign ll_full      = (ll_r >= LEN_W'(MAX_WORD_LEN));
  assign tbl_full     = (wc_r >= WCNT_W'(MAX_WORDS));
  assign ll_inc       = ll_r + LEN_W'(1);
  assign too_long_eff = too_long_r || ll_full;
  assign commit       = !tbl_full && !too_long_eff;
  assign wc_idx       = wc_r[WIDX_W-1:0];
  assign ll_idx       = ll_r[POS_W-1:0];

  // compare the stored word against the newest text bytes, last char on the newest
  always_comb begin
    pos    = '0;
    eq_vec = '0;
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      pos       = len_q - LEN_W'(1) - LEN_W'(j);
      eq_vec[j] = !(LEN_W'(j) < len_q) || (row_q[j] == win_r[pos[POS_W-1:0]]);
    end
  end

  assign len_m1 = len_q - LEN_W'(1);
  assign bh_sel = (len_q == '0) ? 1'b0 : bh_r[len_m1];
  assign hit    = (len_q != '0) && (len_q <= cs_r) && bh_sel && (&eq_vec);

  always_comb begin
    wc_nxt       = wc_r;
    ll_nxt       = ll_r;
    too_long_nxt = too_long_r;
    ovf_nxt      = ovf_r;
    win_nxt      = win_r;
    bh_nxt       = bh_r;
    cs_nxt       = cs_r;
    ok_nxt       = ok_r;

    if (cmd.dict_wr) begin
      if (!ll_full) begin
        ll_nxt = ll_inc;
      end else begin
        too_long_nxt = 1'b1;
      end
      if (in_last) begin
        if (commit) begin
          wc_nxt = wc_r + WCNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        ll_nxt       = '0;
        too_long_nxt = 1'b0;
      end
    end

    if (cmd.clear) begin
      wc_nxt       = '0;
      ll_nxt       = '0;
      too_long_nxt = 1'b0;
      ovf_nxt      = 1'b0;
    end

    if (cmd.text_start) begin
      for (int i = 1; i < MAX_WORD_LEN; i++) begin
        win_nxt[i] = win_r[i-1];
      end
      win_nxt[0] = in_sym;
      if (cs_r < LEN_W'(MAX_WORD_LEN)) begin
        cs_nxt = cs_r + LEN_W'(1);
      end
      ok_nxt = 1'b0;
    end

    if (rd_vld_r) begin
      ok_nxt = ok_r || hit;
    end

    if (cmd.finish) begin
      bh_nxt = {bh_r[MAX_WORD_LEN-1:0], ok_r};
      // restart the text state after the final item
      if (last_r) begin
        win_nxt = '0;
        bh_nxt  = (MAX_WORD_LEN+1)'(1);
        cs_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r       <= '0;
      ll_r       <= '0;
      too_long_r <= 1'b0;
      ovf_r      <= 1'b0;
      win_r      <= '0;
      bh_r       <= (MAX_WORD_LEN+1)'(1);
      cs_r       <= '0;
      rd_vld_r   <= 1'b0;
      ok_r       <= 1'b0;
    end else begin
      wc_r       <= wc_nxt;
      ll_r       <= ll_nxt;
      too_long_r <= too_long_nxt;
      ovf_r      <= ovf_nxt;
      win_r      <= win_nxt;
      bh_r       <= bh_nxt;
      cs_r       <= cs_nxt;
      rd_vld_r   <= cmd.rd_en;
      ok_r       <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dict_wr && !ll_full && !tbl_full) begin
      chars_mem[wc_idx][ll_idx] <= in_sym;
    end
    if (cmd.dict_wr && in_last && commit) begin
      len_mem[wc_idx] <= ll_inc;
    end
    if (cmd.rd_en) begin
      row_q <= chars_mem[cmd.rd_addr];
      len_q <= len_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.text_start) begin
      last_r <= in_last;
    end
    if (cmd.finish) begin
      prefix_q    <= ok_r;
      text_last_q <= last_r;
      ovf_q       <= ovf_r;
    end
  end

endmodule

/* rtl/word_break_segmenter_unit.sv */
// Word-break segmenter.
// Input channel in_*: in_tuser carries the kind (dictionary byte, text byte,
// clear table), in_tdata the byte, in_tlast ends a dictionary word or a text.
// Dictionary bytes build words in a table of MAX_WORDS words of at most
// MAX_WORD_LEN bytes; words too long or past a full table are dropped and set
// the sticky overflow bit. A clear item empties the table and the overflow bit.
// Each text byte yields one result item on out_*: out_tdata bit 0 says the text
// so far splits into table words, bit 1 is the overflow bit, out_tlast marks
// the answer for the whole text, after which the text state restarts.
// Dictionary and clear items give no result and do not stall the input.
// A text item scans the table one stored word per cycle from a single read
// port, then passes a drain state and a finish state that writes the result
// once the output register is free (straight to finish with an empty table);
// the next item is taken only after that.
// Reset empties the table and restarts the text state; no clearing pass.
// A result waits in the output register while out_tready is low; dictionary
// and clear items are still taken, and the next text result waits behind it.
module word_break_segmenter_unit
  import wbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic [1:0] in_tuser,   // [1:0] kind
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] prefix_ok, [1] dict_overflow, [7:2] zero
  output logic       out_tlast
);

  wbs_cmd_t cmd;
  wbs_sts_t sts;
  logic     prefix_ok;
  logic     dict_overflow;

  wbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  wbs_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_sym        (in_tdata),
    .in_last       (in_tlast),
    .cmd           (cmd),
    .sts           (sts),
    .prefix_ok     (prefix_ok),
    .text_last     (out_tlast),
    .dict_overflow (dict_overflow)
  );

  assign out_tdata = {6'b0, dict_overflow, prefix_ok};

endmodule

/* rtl/wbs_checker.sv */
module wbs_checker
  import wbs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a text item holds off the input while the table is scanned
  a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == KIND_TEXT) |=> !in_tready)
    else $error("input taken during a table scan");

  // dictionary, clear and unused-kind items leave the input ready
  a_dict_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser != KIND_TEXT) |=> in_tready)
    else $error("non-text item stalled the input");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:2] == 6'b0))
    else $error("padding bits of result not zero");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("reset did not empty the block");

endmodule

bind word_break_segmenter_unit wbs_checker u_chk (.*);

/* test/wbs_segment_checker.sv */
module wbs_segment_checker
  import wbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [1:0] in_tuser,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  output int         fail_count,
  output int         due_count
);

  typedef struct packed {
    logic prefix_ok;
    logic text_last;
    logic dict_overflow;
  } answer_t;

  answer_t answers_due [$];
  int      mismatches;

  // own copy of the word table and text state
  logic [7:0]            word_bytes [MAX_WORDS][MAX_WORD_LEN];
  int                    word_size  [MAX_WORDS];
  int                    stored;
  int                    load_pos;
  logic                  load_long;
  logic                  overflow;
  logic [7:0]            window     [MAX_WORD_LEN];
  logic [MAX_WORD_LEN:0] seg_ok;
  int                    seen;

  function automatic void restart_text();
    for (int i = 0; i < MAX_WORD_LEN; i++) window[i] = 8'h00;
    seg_ok = '0;
    seg_ok[0] = 1'b1;
    seen = 0;
  endfunction

  function automatic void segment_step(kind_t kind, logic [7:0] sym, logic lst);
    logic   hit;
    logic   match;
    int     len;
    answer_t ans;
    case (kind)
      KIND_DICT: begin
        if (load_pos < MAX_WORD_LEN) begin
          if (stored < MAX_WORDS) word_bytes[stored][load_pos] = sym;
          load_pos++;
        end else begin
          load_long = 1'b1;
        end
        if (lst) begin
          if (stored < MAX_WORDS && !load_long) begin
            word_size[stored] = load_pos;
            stored++;
          end else begin
            overflow = 1'b1;
          end
          load_pos  = 0;
          load_long = 1'b0;
        end
      end
      KIND_CLEAR: begin
        stored    = 0;
        load_pos  = 0;
        load_long = 1'b0;
        overflow  = 1'b0;
      end
      KIND_TEXT: begin
        for (int i = MAX_WORD_LEN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = sym;
        if (seen < MAX_WORD_LEN) seen++;
        hit = 1'b0;
        for (int w = 0; w < stored; w++) begin
          len = word_size[w];
          // word must fit in the text seen so far and start on a segment boundary
          if (len == 0 || len > seen) continue;
          if (!seg_ok[len-1]) continue;
          match = 1'b1;
          for (int j = 0; j < len; j++)
            if (word_bytes[w][j] != window[len-1-j]) match = 1'b0;
          if (match) hit = 1'b1;
        end
        seg_ok = {seg_ok[MAX_WORD_LEN-1:0], hit};
        ans.prefix_ok     = hit;
        ans.text_last     = lst;
        ans.dict_overflow = overflow;
        answers_due.push_back(ans);
        if (lst) restart_text();
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    answer_t exp;
    if (!rst_n) begin
      answers_due.delete();
      mismatches = 0;
      stored     = 0;
      load_pos   = 0;
      load_long  = 1'b0;
      overflow   = 1'b0;
      restart_text();
    end else begin
      if (out_tvalid && out_tready) begin
        if (answers_due.size() == 0) begin
          $error("result item with none expected: tdata %0h, tlast %0b", out_tdata, out_tlast);
          mismatches++;
        end else begin
          exp = answers_due.pop_front();
          check_field("prefix_ok", 8'(exp.prefix_ok), 8'(out_tdata[0]));
          check_field("dict_overflow", 8'(exp.dict_overflow), 8'(out_tdata[1]));
          check_field("text_last", 8'(exp.text_last), 8'(out_tlast));
          check_field("tdata pad", 8'h00, 8'(out_tdata[7:2]));
        end
      end
      if (in_tvalid && in_tready) segment_step(kind_t'(in_tuser), in_tdata, in_tlast);
    end
    fail_count <= mismatches;
    due_count  <= answers_due.size();
  end

endmodule

/* test/tb_word_break_segmenter_unit.sv */
module tb_word_break_segmenter_unit;
  import wbs_pkg::*;

  localparam kind_t KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_GOAL   = 1350;
  localparam int SETTLE      = MAX_WORDS + 8;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic [1:0] in_tuser   = KIND_DICT;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tlast;

  int fail_count;
  int due_count;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int sent          = 0;
  int cycles        = 0;

  // words known to the stimulus side, used to build texts that segment
  logic [7:0] lex [128][20];
  int         lex_len [128];
  int         lex_n;
  logic [7:0] alphabet [3];
  int         alpha_n;

  always #10 clk = ~clk;

  always @(posedge clk) out_tready <= ($urandom_range(99, 0) >= stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("word_break_segmenter_unit regression: fail");
      $finish;
    end
  end

  word_break_segmenter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  wbs_segment_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  task automatic push_item(kind_t kind, logic [7:0] sym, logic lst);
    int gap;
    gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= sym;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    if (kind != KIND_UNUSED) sent++;
  endtask

  // hold off the sender until every outstanding answer has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(99, 0) < 3) return 8'($urandom_range(255, 0));
    return alphabet[$urandom_range(alpha_n - 1, 0)];
  endfunction

  task automatic push_noise();
    push_item(kind_t'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
              1'($urandom_range(1, 0)));
  endtask

  task automatic make_word(int idx, bit stress);
    int r;
    r = $urandom_range(99, 0);
    if (stress && r < 90)  lex_len[idx] = $urandom_range(2, 1);
    else if (r < 70)       lex_len[idx] = $urandom_range(4, 1);
    else if (r < 85)       lex_len[idx] = $urandom_range(15, 5);
    else if (r < 93)       lex_len[idx] = MAX_WORD_LEN;
    else                   lex_len[idx] = $urandom_range(MAX_WORD_LEN + 3, MAX_WORD_LEN + 1);
    for (int b = 0; b < lex_len[idx]; b++) lex[idx][b] = pick_symbol();
  endtask

  task automatic load_word(int idx);
    for (int b = 0; b < lex_len[idx]; b++) begin
      // occasionally interleave other items with the load
      if ($urandom_range(29, 0) == 0) push_noise();
      push_item(KIND_DICT, lex[idx][b], b == lex_len[idx] - 1);
    end
  endtask

  task automatic run_text();
    logic [7:0] txt [$];
    int         idx;
    int         n;
    txt.delete();
    if ($urandom_range(9, 0) == 0) begin
      n = $urandom_range(30, 1);
      for (int i = 0; i < n; i++) txt.push_back(pick_symbol());
    end else begin
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
        idx = $urandom_range(lex_n - 1, 0);
        for (int b = 0; b < lex_len[idx]; b++) txt.push_back(lex[idx][b]);
      end
      if ($urandom_range(99, 0) < 15)
        txt[$urandom_range(txt.size() - 1, 0)] = 8'($urandom_range(255, 0));
      if ($urandom_range(99, 0) < 5) txt.push_back(pick_symbol());
    end
    for (int i = 0; i < txt.size(); i++)
      push_item(KIND_TEXT, txt[i], i == txt.size() - 1);
  endtask

  task automatic run_session(int s);
    bit stress;
    stress = (s % 5 == 4);
    case ((s / 2) % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 47; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 47; end
      default: begin send_idle_pct = 18; stall_pct = 18; end
    endcase
    alpha_n = $urandom_range(3, 2);
    for (int i = 0; i < alpha_n; i++) alphabet[i] = 8'($urandom_range(255, 0));
    if (stress || $urandom_range(9, 0) < 7) push_item(KIND_CLEAR, 8'($urandom_range(255, 0)),
                                                      1'($urandom_range(1, 0)));
    lex_n = stress ? $urandom_range(MAX_WORDS + 6, MAX_WORDS - 4) : $urandom_range(10, 1);
    for (int i = 0; i < lex_n; i++) begin
      make_word(i, stress);
      load_word(i);
    end
    repeat ($urandom_range(stress ? 2 : 4, 1)) run_text();
    if ($urandom_range(3, 0) == 0) repeat ($urandom_range(4, 1)) push_noise();
    if (s % 6 == 5) wait_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    push_item(KIND_CLEAR, 8'h00, 1'b0);
    push_item(KIND_DICT, 8'h00, 1'b1);
    push_item(KIND_DICT, 8'hFF, 1'b1);
    push_item(KIND_UNUSED, 8'h00, 1'b1);
    push_item(KIND_TEXT, 8'h00, 1'b0);
    push_item(KIND_TEXT, 8'hFF, 1'b1);
    push_item(KIND_TEXT, 8'hFF, 1'b0);
    // half-loaded word must not match yet
    push_item(KIND_DICT, 8'h01, 1'b0);
    push_item(KIND_TEXT, 8'h01, 1'b0);
    push_item(KIND_DICT, 8'h02, 1'b1);
    push_item(KIND_TEXT, 8'h02, 1'b1);
    push_item(KIND_TEXT, 8'h7F, 1'b1);
    // clear drops the partial word and leaves an empty table
    push_item(KIND_DICT, 8'hAA, 1'b0);
    push_item(KIND_CLEAR, 8'hFF, 1'b1);
    push_item(KIND_TEXT, 8'hAA, 1'b1);
    wait_drain();

    for (int s = 0; sent < ITEM_GOAL; s++) run_session(s);

    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("word_break_segmenter_unit regression: pass");
    else
      $display("word_break_segmenter_unit regression: fail");
    $finish;
  end

endmodule
